// File: hw/rtl/ihex_pkg.sv
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types, constants and helpers of the Intel HEX record loader.
// ----------------------------------------------------------------------------
package ihex_pkg;

	// Default width of absolute addresses.
	localparam int ADDR_WIDTH_DEF = 32;

	// Configuration port.
	localparam int          CFG_INDEX_W      = 2;
	localparam logic [1:0]  REG_WINDOW_BASE  = 2'd0;
	localparam logic [1:0]  REG_WINDOW_LIMIT = 2'd1;

	// Result kinds.
	localparam logic [1:0] KIND_WRITE   = 2'd0;
	localparam logic [1:0] KIND_OUTSIDE = 2'd1;
	localparam logic [1:0] KIND_UNKNOWN = 2'd2;
	localparam logic [1:0] KIND_EOF     = 2'd3;

	// Low digit of the record type.
	localparam logic [3:0] REC_DATA   = 4'd0;
	localparam logic [3:0] REC_EOF    = 4'd1;
	localparam logic [3:0] REC_SEG    = 4'd2;
	localparam logic [3:0] REC_LIN    = 4'd4;
	localparam logic [3:0] REC_START  = 4'd5;
	localparam logic [3:0] REC_BAD    = 4'd15;

	// Characters.
	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_0  = 8'h30;
	localparam logic [7:0] CHAR_9  = 8'h39;
	localparam logic [7:0] CHAR_UA = 8'h41;
	localparam logic [7:0] CHAR_UF = 8'h46;
	localparam logic [7:0] CHAR_LA = 8'h61;
	localparam logic [7:0] CHAR_LF_HEX = 8'h66;

	// One result item.
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] write_offset;
		logic [7:0]  write_byte;
	} result_t;

	// Value of a hex digit; anything else counts as zero.
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= CHAR_0 && c <= CHAR_9) begin
			v = c[3:0];
		end else if (c >= CHAR_UA && c <= CHAR_UF) begin
			v = 4'(c - 8'h37);
		end else if (c >= CHAR_LA && c <= CHAR_LF_HEX) begin
			v = 4'(c - 8'h57);
		end
		return v;
	endfunction

endpackage

// File: hw/rtl/intel_hex_record_loader_core.sv
// A character accepted on the input passes the input register and then the result
// register before its result item shows. Throughput: one character per cycle
// unless the output stalls; the parser state update is a single pass.
// A stalled output holds one result and the skid stage one more before s_tready drops.
// Reset (arst_n low) clears the window registers, all parser state and both output slots.
// ----------------------------------------------------------------------------
// intel_hex_record_loader_core
// Parses an Intel HEX character stream into byte writes within an address
// window, with flags for outside records, unknown types and end of file.
// ----------------------------------------------------------------------------
module intel_hex_record_loader_core #(
	parameter int ADDR_WIDTH = ihex_pkg::ADDR_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// tdata: [7:0] text_char
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,
	// tdata: [31:0] write_offset, [39:32] write_byte
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [39:0]                      m_tdata,
	// tuser: [1:0] kind
	output logic [1:0]                       m_tuser,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ihex_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]                      cfg_data
);
	import ihex_pkg::*;

	logic [31:0] window_base_q;
	logic [31:0] window_limit_q;
	logic        res_valid;
	logic        res_ready;
	result_t     res;
	result_t     out_data;

	assign cfg_ready = 1'b1;

	// Window registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_base_q  <= '0;
			window_limit_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_WINDOW_BASE:  window_base_q  <= cfg_data;
				REG_WINDOW_LIMIT: window_limit_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	ihex_parser #(
		.ADDR_WIDTH(ADDR_WIDTH)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_char     (s_tdata),
		.window_base (window_base_q),
		.window_limit(window_limit_q),
		.res_ready   (res_ready),
		.res_valid   (res_valid),
		.res         (res)
	);

	ihex_out_skid u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_valid),
		.push_data(res),
		.ready    (res_ready),
		.m_valid  (m_tvalid),
		.m_ready  (m_tready),
		.m_data   (out_data)
	);

	assign m_tdata = {out_data.write_byte, out_data.write_offset};
	assign m_tuser = out_data.kind;

endmodule

// File: hw/rtl/ihex_parser.sv
// ----------------------------------------------------------------------------
// ihex_parser
// Input register and record parser: while res_ready is high, updates the line
// state for one character per cycle and forms at most one result item for it.
// ----------------------------------------------------------------------------
module ihex_parser #(
	parameter int ADDR_WIDTH = ihex_pkg::ADDR_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       in_char,
	input  logic [31:0]      window_base,
	input  logic [31:0]      window_limit,
	input  logic             res_ready,
	output logic             res_valid,
	output ihex_pkg::result_t res
);
	import ihex_pkg::*;

	// Character positions within a line.
	localparam logic [9:0] POS_COUNT_HI = 10'd1;
	localparam logic [9:0] POS_COUNT_LO = 10'd2;
	localparam logic [9:0] POS_ADDR_0   = 10'd3;
	localparam logic [9:0] POS_ADDR_1   = 10'd4;
	localparam logic [9:0] POS_ADDR_2   = 10'd5;
	localparam logic [9:0] POS_ADDR_3   = 10'd6;
	localparam logic [9:0] POS_TYPE     = 10'd8;
	localparam logic [9:0] POS_DATA     = 10'd9;
	localparam logic [9:0] POS_OFS_LAST = 10'd12;
	localparam logic [9:0] POS_MAX      = 10'd1023;

	// Input stage.
	logic [7:0] char_s1;
	logic       valid_s1;
	logic       fire;

	// Line and record state.
	logic [9:0]            pos_q, pos_d;
	logic [7:0]            count_q, count_d;
	logic [15:0]           acc_q, acc_d;
	logic [3:0]            kdig_q, kdig_d;
	logic [ADDR_WIDTH-1:0] upper_q, upper_d;
	logic [ADDR_WIDTH-1:0] start_q, start_d;
	logic [ADDR_WIDTH:0]   cur_q, cur_d;
	logic [7:0]            emitted_q, emitted_d;
	logic                  in_window_q, in_window_d;

	// Per-character terms.
	logic [3:0]            digit;
	logic [15:0]           shifted;
	logic [3:0]            kdig_new;
	logic [ADDR_WIDTH-1:0] base_m;
	logic [ADDR_WIDTH-1:0] limit_m;
	logic [31:0]           upper_wide;

	assign fire     = valid_s1 && res_ready;
	assign in_ready = !valid_s1 || fire;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= in_char;
		end
	end

	assign digit    = hex_value(char_s1);
	assign shifted  = {acc_q[11:0], digit};
	assign base_m   = window_base[ADDR_WIDTH-1:0];
	assign limit_m  = window_limit[ADDR_WIDTH-1:0];
	assign kdig_new = (char_s1 >= CHAR_0 && char_s1 <= CHAR_9) ? char_s1[3:0] : REC_BAD;
	assign upper_wide = (kdig_q == REC_SEG) ? {12'd0, shifted, 4'd0} : {shifted, 16'd0};

	// Next state and result for the character in the input register.
	always_comb begin
		pos_d       = pos_q;
		count_d     = count_q;
		acc_d       = acc_q;
		kdig_d      = kdig_q;
		upper_d     = upper_q;
		start_d     = start_q;
		cur_d       = cur_q;
		emitted_d   = emitted_q;
		in_window_d = in_window_q;
		res_valid   = 1'b0;
		res         = '0;
		if (fire) begin
			if (char_s1 == CHAR_LF) begin
				pos_d       = '0;
				in_window_d = 1'b0;
			end else if (char_s1 != CHAR_CR) begin
				if (pos_q != POS_MAX) begin
					pos_d = pos_q + 10'd1;
				end
				priority if (pos_q == POS_COUNT_HI || pos_q == POS_ADDR_0) begin
					acc_d = {12'd0, digit};
				end else if (pos_q == POS_COUNT_LO) begin
					acc_d   = shifted;
					count_d = shifted[7:0];
				end else if (pos_q == POS_ADDR_1 || pos_q == POS_ADDR_2) begin
					acc_d = shifted;
				end else if (pos_q == POS_ADDR_3) begin
					// The record start address is formed as soon as the address is known.
					acc_d   = shifted;
					start_d = upper_q + ADDR_WIDTH'(shifted);
				end else if (pos_q == POS_TYPE) begin
					kdig_d      = kdig_new;
					emitted_d   = '0;
					in_window_d = 1'b0;
					cur_d       = {1'b0, start_q};
					unique case (kdig_new)
						REC_DATA: begin
							if (start_q >= base_m && start_q <= limit_m) begin
								in_window_d = 1'b1;
							end else begin
								res_valid = 1'b1;
								res.kind  = KIND_OUTSIDE;
							end
						end
						REC_EOF: begin
							res_valid = 1'b1;
							res.kind  = KIND_EOF;
						end
						REC_SEG, REC_LIN, REC_START: begin
						end
						default: begin
							res_valid = 1'b1;
							res.kind  = KIND_UNKNOWN;
						end
					endcase
				end else if (pos_q >= POS_DATA) begin
					if (kdig_q == REC_DATA) begin
						if (pos_q[0]) begin
							acc_d = {12'd0, digit};
						end else begin
							acc_d = shifted;
							if (emitted_q < count_q) begin
								emitted_d = emitted_q + 8'd1;
								cur_d     = cur_q + (ADDR_WIDTH+1)'(1);
								// Bytes past the window end are dropped.
								if (in_window_q && !cur_q[ADDR_WIDTH] &&
									cur_q[ADDR_WIDTH-1:0] <= limit_m) begin
									res_valid        = 1'b1;
									res.kind         = KIND_WRITE;
									res.write_offset = 32'(cur_q[ADDR_WIDTH-1:0] - base_m);
									res.write_byte   = shifted[7:0];
								end
							end
						end
					end else if (kdig_q == REC_SEG || kdig_q == REC_LIN) begin
						if (pos_q == POS_DATA) begin
							acc_d = {12'd0, digit};
						end else if (pos_q <= POS_OFS_LAST) begin
							acc_d = shifted;
							if (pos_q == POS_OFS_LAST) begin
								upper_d = ADDR_WIDTH'(upper_wide);
							end
						end
					end
				end else begin
					// The leading colon and the high type digit are skipped.
				end
			end
		end
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			count_q     <= '0;
			acc_q       <= '0;
			kdig_q      <= '0;
			upper_q     <= '0;
			start_q     <= '0;
			cur_q       <= '0;
			emitted_q   <= '0;
			in_window_q <= 1'b0;
		end else begin
			pos_q       <= pos_d;
			count_q     <= count_d;
			acc_q       <= acc_d;
			kdig_q      <= kdig_d;
			upper_q     <= upper_d;
			start_q     <= start_d;
			cur_q       <= cur_d;
			emitted_q   <= emitted_d;
			in_window_q <= in_window_d;
		end
	end

	// A byte write comes only from a record that started inside the window.
	a_write_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == KIND_WRITE |-> in_window_q && kdig_q == REC_DATA)
		else $error("byte write outside an accepted data record");

	// Flags carry no offset and no byte.
	a_flag_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind != KIND_WRITE |-> res.write_offset == '0 && res.write_byte == '0)
		else $error("flag result with nonzero payload");

	// The position saturates and only a line feed brings it back.
	a_pos_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q == POS_MAX |=> pos_q == POS_MAX || pos_q == '0)
		else $error("character position wrapped");

endmodule

// File: hw/rtl/ihex_out_skid.sv
// ----------------------------------------------------------------------------
// ihex_out_skid
// Result register with a skid stage, so that the parser keeps going for
// one more item while the consumer stalls.
// ----------------------------------------------------------------------------
module ihex_out_skid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ihex_pkg::result_t push_data,
	output logic              ready,
	output logic              m_valid,
	input  logic              m_ready,
	output ihex_pkg::result_t m_data
);
	import ihex_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    pop;

	assign pop     = out_valid_q && m_ready;
	assign ready   = !skid_valid_q;
	assign m_valid = out_valid_q;
	assign m_data  = out_q;

	// Valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload: the skid entry is older than a new push.
	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			out_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	// The skid entry is only ever filled behind a held result.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry without a result in front");

	// The parser never pushes into a full skid stage.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !push)
		else $error("push into full skid stage");

	// Draining the result moves the skid entry forward.
	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		pop && skid_valid_q |=> out_valid_q && !skid_valid_q)
		else $error("skid entry lost on drain");

endmodule

// File: tb/intel_hex_record_loader_core_tb.sv
// ----------------------------------------------------------------------------
// intel_hex_record_loader_core_tb
// Feeds Intel HEX text into the record loader one character per item and
// checks every write, outside-window flag, unknown-type flag and end-of-file
// report against a parser kept inside the testbench. Directed records come
// first, then one very long line, then random record streams under several
// window settings, all but the first with random gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------
module intel_hex_record_loader_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ihex_pkg::*;

	localparam int         CLK_PERIOD    = 20;
	localparam int         CYCLE_LIMIT   = 1000000;
	localparam int         SETTLE_CYCLES = 8;
	localparam logic [9:0] POS_LIMIT     = 10'd1023;
	localparam logic [7:0] CHAR_COLON    = 8'h3A;
	localparam logic [1:0] REG_UNUSED_2  = 2'd2;
	localparam logic [1:0] REG_UNUSED_3  = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	// Parser state as the testbench sees it.
	logic [31:0] win_base      = '0;
	logic [31:0] win_limit     = '0;
	logic [9:0]  char_pos      = '0;
	logic [7:0]  rec_count     = '0;
	logic [15:0] rec_address   = '0;
	logic [3:0]  rec_type      = '0;
	logic [31:0] upper_offset  = '0;
	logic [15:0] field_acc     = '0;
	logic [7:0]  bytes_done    = '0;
	logic        rec_in_window = 1'b0;

	result_t     pending_events[$];
	logic [7:0]  line_buf[$];
	int          err_count   = 0;
	int          chars_sent  = 0;
	int          cycle_count = 0;
	int          stall_left  = 0;
	bit          tx_gaps_on  = 1'b1;
	bit          rx_stalls_on = 1'b1;

	intel_hex_record_loader_core #(
		.ADDR_WIDTH(32)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Output back-pressure: mostly ready, short stalls, now and then a long one.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_tready <= 1'b1;
			if (rx_stalls_on) begin
				stall_left <= pick_idle();
			end
		end
	end

	// Compare every accepted result item with the oldest predicted one.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_events.size() == 0) begin
				$display("%0t: unexpected item kind %0d offset %h data %h", $time,
					m_tuser, m_tdata[31:0], m_tdata[39:32]);
				err_count++;
			end else begin
				want = pending_events.pop_front();
				if (m_tuser !== want.kind) begin
					$display("%0t: kind expected %0d actual %0d", $time, want.kind, m_tuser);
					err_count++;
				end
				if (m_tdata[31:0] !== want.write_offset) begin
					$display("%0t: write_offset expected %h actual %h", $time,
						want.write_offset, m_tdata[31:0]);
					err_count++;
				end
				if (m_tdata[39:32] !== want.write_byte) begin
					$display("%0t: write_byte expected %h actual %h", $time,
						want.write_byte, m_tdata[39:32]);
					err_count++;
				end
			end
		end
	end

	// Idle length for either side: mostly none, some short, a few long.
	function automatic int pick_idle();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 72) return 0;
		if (sel < 94) return $urandom_range(1, 3);
		return $urandom_range(10, 45);
	endfunction

	function automatic logic [3:0] digit_value(input logic [7:0] c);
		if (c >= CHAR_0 && c <= CHAR_9) return 4'(c - CHAR_0);
		if (c >= CHAR_UA && c <= CHAR_UF) return 4'(c - CHAR_UA + 8'd10);
		if (c >= CHAR_LA && c <= CHAR_LF_HEX) return 4'(c - CHAR_LA + 8'd10);
		return 4'd0;
	endfunction

	function automatic void push_event(input logic [1:0] kind, input logic [31:0] offset,
		input logic [7:0] data);
		result_t ev;
		ev.kind = kind;
		ev.write_offset = offset;
		ev.write_byte = data;
		pending_events.push_back(ev);
	endfunction

	// Advance the parser by one accepted character and queue its result, if any.
	function automatic void decode_char(input logic [7:0] c);
		logic [9:0]  pos;
		logic [3:0]  d;
		logic [15:0] sh;
		logic [32:0] start;
		logic [32:0] byte_addr;
		pos = char_pos;
		d = digit_value(c);
		sh = {field_acc[11:0], d};
		start = {1'b0, upper_offset + {16'd0, rec_address}};
		if (c == CHAR_CR) begin
			// Carriage return leaves everything as it is.
		end else if (c == CHAR_LF) begin
			char_pos = '0;
			rec_in_window = 1'b0;
		end else begin
			if (char_pos != POS_LIMIT) char_pos = char_pos + 10'd1;
			if (pos == 10'd1 || pos == 10'd3) begin
				field_acc = {12'd0, d};
			end else if (pos == 10'd2) begin
				field_acc = sh;
				rec_count = sh[7:0];
			end else if (pos == 10'd4 || pos == 10'd5) begin
				field_acc = sh;
			end else if (pos == 10'd6) begin
				field_acc = sh;
				rec_address = sh;
			end else if (pos == 10'd8) begin
				rec_type = (c >= CHAR_0 && c <= CHAR_9) ? c[3:0] : REC_BAD;
				bytes_done = '0;
				rec_in_window = 1'b0;
				case (rec_type)
					REC_DATA: begin
						if (start[31:0] >= win_base && start[31:0] <= win_limit) begin
							rec_in_window = 1'b1;
						end else begin
							push_event(KIND_OUTSIDE, '0, '0);
						end
					end
					REC_EOF: push_event(KIND_EOF, '0, '0);
					REC_SEG, REC_LIN, REC_START: begin
					end
					default: push_event(KIND_UNKNOWN, '0, '0);
				endcase
			end else if (pos >= 10'd9) begin
				if (rec_type == REC_DATA) begin
					if (pos[0]) begin
						field_acc = {12'd0, d};
					end else begin
						field_acc = sh;
						// Bytes past the count are checksum or trailing text.
						if (bytes_done < rec_count) begin
							byte_addr = start + {25'd0, bytes_done};
							bytes_done = bytes_done + 8'd1;
							if (rec_in_window && byte_addr <= {1'b0, win_limit}) begin
								push_event(KIND_WRITE, byte_addr[31:0] - win_base, sh[7:0]);
							end
						end
					end
				end else if (rec_type == REC_SEG || rec_type == REC_LIN) begin
					if (pos == 10'd9) begin
						field_acc = {12'd0, d};
					end else if (pos <= 10'd12) begin
						field_acc = sh;
						if (pos == 10'd12) begin
							upper_offset = (rec_type == REC_SEG) ? {12'd0, sh, 4'd0}
								: {sh, 16'd0};
						end
					end
				end
			end
		end
	endfunction

	task automatic send_char(input logic [7:0] c);
		int gap;
		gap = tx_gaps_on ? pick_idle() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		do @(posedge clk); while (!s_tready);
		decode_char(c);
		chars_sent++;
	endtask

	task automatic send_line();
		foreach (line_buf[i]) send_char(line_buf[i]);
		line_buf.delete();
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
		send_line();
	endtask

	// Drain: no input, nothing predicted outstanding, then a settling wait.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_events.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		if (idx == REG_WINDOW_BASE) win_base = value;
		else if (idx == REG_WINDOW_LIMIT) win_limit = value;
	endtask

	// Hex text building; letters come in either case.
	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10) return CHAR_0 + 8'(v);
		return ($urandom_range(0, 1) ? CHAR_LA : CHAR_UA) + 8'(v - 4'd10);
	endfunction

	function automatic void put_hex(input logic [31:0] v, input int digits);
		for (int i = digits - 1; i >= 0; i--) line_buf.push_back(hex_char(v[i*4 +: 4]));
	endfunction

	function automatic logic [7:0] type_char(input logic [3:0] rec);
		return CHAR_0 + 8'(rec);
	endfunction

	function automatic void put_header(input logic [7:0] cnt, input logic [15:0] addr,
		input logic [7:0] type_ch);
		line_buf.push_back(CHAR_COLON);
		put_hex(32'(cnt), 2);
		put_hex(32'(addr), 4);
		// The high type digit is never looked at.
		line_buf.push_back(($urandom_range(0, 9) == 0) ? hex_char(4'($urandom)) : CHAR_0);
		line_buf.push_back(type_ch);
	endfunction

	function automatic void put_line_end();
		put_hex($urandom, 2);
		if ($urandom_range(0, 1)) line_buf.push_back(CHAR_CR);
		line_buf.push_back(CHAR_LF);
	endfunction

	task automatic send_data_record(input logic [7:0] cnt, input logic [15:0] addr,
		input int nbytes);
		put_header(cnt, addr, type_char(REC_DATA));
		for (int i = 0; i < nbytes; i++) put_hex($urandom, 2);
		put_line_end();
		send_line();
	endtask

	task automatic send_offset_record(input logic [3:0] rec, input logic [15:0] value);
		put_header(8'd2, 16'd0, type_char(rec));
		put_hex(32'(value), 4);
		put_line_end();
		send_line();
	endtask

	task automatic send_plain_record(input logic [7:0] type_ch);
		put_header(8'd0, 16'($urandom), type_ch);
		put_line_end();
		send_line();
	endtask

	function automatic logic [31:0] pick_target();
		logic [31:0] span;
		int sel;
		span = (win_limit >= win_base) ? win_limit - win_base : 32'd64;
		if (span > 32'd64) span = 32'd64;
		sel = $urandom_range(0, 99);
		if (sel < 70) return win_base + $urandom_range(0, span + 4);
		if (sel < 85) return win_limit - $urandom_range(0, 8);
		return $urandom;
	endfunction

	function automatic logic [7:0] pick_count();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 2) return 8'($urandom_range(33, 255));
		if (sel < 17) return 8'($urandom_range(9, 32));
		return 8'($urandom_range(0, 8));
	endfunction

	// Type character that the loader must flag as unknown.
	function automatic logic [7:0] pick_unknown_type();
		logic [7:0] c;
		if ($urandom_range(0, 1)) begin
			do c = type_char(4'($urandom_range(3, 9)));
			while (c == type_char(REC_LIN) || c == type_char(REC_START));
		end else begin
			do c = 8'($urandom);
			while ((c >= CHAR_0 && c <= CHAR_9) || c == CHAR_LF || c == CHAR_CR);
		end
		return c;
	endfunction

	// A record cut short inside its header or its payload.
	task automatic send_truncated();
		logic [7:0] cnt;
		logic [7:0] type_ch;
		int ndig;
		cnt = pick_count() + 8'd1;
		if (cnt == 8'd0) cnt = 8'd1;
		type_ch = ($urandom_range(0, 2) == 0) ? type_char(REC_LIN) : type_char(REC_DATA);
		put_header(cnt, 16'(pick_target()), type_ch);
		if ($urandom_range(0, 4) == 0) begin
			line_buf = line_buf[0:$urandom_range(0, 7)];
		end else begin
			ndig = (type_ch == type_char(REC_LIN)) ? $urandom_range(0, 3)
				: $urandom_range(0, 2 * cnt - 1);
			for (int i = 0; i < ndig; i++) line_buf.push_back(hex_char(4'($urandom)));
		end
		line_buf.push_back(CHAR_LF);
		send_line();
	endtask

	task automatic send_noise();
		int len;
		len = $urandom_range(1, 24);
		for (int i = 0; i < len; i++) line_buf.push_back(8'($urandom));
		if ($urandom_range(0, 1)) line_buf.push_back(CHAR_LF);
		send_line();
	endtask

	// One window setting, then a random stream of mostly well-formed records.
	task automatic run_random_phase(input logic [31:0] base, input logic [31:0] limit,
		input int char_budget);
		int stop_at;
		int sel;
		int nbytes;
		logic [31:0] aim;
		logic [7:0] cnt;
		wait_idle();
		write_reg(REG_WINDOW_BASE, base);
		write_reg(REG_WINDOW_LIMIT, limit);
		stop_at = chars_sent + char_budget;
		while (chars_sent < stop_at) begin
			sel = $urandom_range(0, 99);
			if (sel < 55) begin
				aim = pick_target();
				if (upper_offset != {aim[31:16], 16'd0}) send_offset_record(REC_LIN, aim[31:16]);
				cnt = pick_count();
				nbytes = int'(cnt);
				if ($urandom_range(0, 9) == 0) nbytes = nbytes + $urandom_range(1, 3);
				send_data_record(cnt, aim[15:0], nbytes);
			end else if (sel < 65) begin
				send_offset_record($urandom_range(0, 1) ? REC_SEG : REC_LIN, 16'($urandom));
			end else if (sel < 70) begin
				send_plain_record(type_char(REC_EOF));
			end else if (sel < 74) begin
				send_plain_record(type_char(REC_START));
			end else if (sel < 80) begin
				send_plain_record(pick_unknown_type());
			end else if (sel < 88) begin
				send_truncated();
			end else begin
				send_noise();
			end
		end
	endtask

	// Window after reset covers address zero only.
	task automatic test_reset_window();
		send_text(":0100000055AA\r\n");
		send_text(":02000000ABCD00\n");
	endtask

	// One record per special case, in a window of 0x1000 to 0x10FF.
	task automatic test_directed_records();
		wait_idle();
		write_reg(REG_WINDOW_BASE, 32'h0000_1000);
		write_reg(REG_WINDOW_LIMIT, 32'h0000_10FF);
		send_text(":04100000DeadBEef00\r\n");
		// Runs past the window end: the last two bytes are dropped.
		send_text(":0410FE001122334400\n");
		send_text(":020FFF00AABB00\n");
		send_text(":00000001FF\n");
		send_text(":00000003FC\n");
		send_text(":0000000G00\n");
		send_text(":00000009F7\n");
		send_text(":04000005000000CD2A\n");
		// Linear offset moves the record out; segment offset brings it back.
		send_text(":020000040001F9\n");
		send_text(":0100000077\n");
		send_text(":020000020100FB\n");
		send_text(":0100100088\n");
		// Non-hex characters in the address and data count as zero.
		send_text(":02x0x000zz5g\n");
		send_text(":020000040000FA\n");
		send_text(":081020000102030\n");
		// An offset record missing its last digit changes nothing.
		send_text(":02000004000\n");
		send_text(":0110400099\n");
		send_text(":01\r10500042\n");
		send_text(":011060005566778899\n");
		send_text("X01107000AB\n");
		send_text(":00108000\n");
		send_text(":011090107E\n");
		send_text(":FF\n");
	endtask

	// A line long enough to saturate the character position.
	task automatic test_long_line();
		logic [7:0] c;
		send_text(":021020001234");
		for (int i = 0; i < 1040; i++) begin
			c = 8'($urandom);
			if (c == CHAR_LF) c = 8'hFF;
			line_buf.push_back(c);
		end
		line_buf.push_back(CHAR_LF);
		send_line();
		send_text(":0110A000C3\n");
	endtask

	// Random streams under full, top-end, empty, random and single-byte windows.
	task automatic test_random_records();
		logic [31:0] lo;
		tx_gaps_on = 1'b0;
		rx_stalls_on = 1'b0;
		run_random_phase(32'h0000_0000, 32'hFFFF_FFFF, 110);
		tx_gaps_on = 1'b1;
		rx_stalls_on = 1'b1;
		run_random_phase(32'hFFFF_FF00, 32'hFFFF_FFFF, 110);
		run_random_phase(32'h0000_1000, 32'h0000_0FFF, 90);
		lo = $urandom;
		run_random_phase(lo, lo + $urandom_range(0, 511), 110);
		// Writes to indexes past the last register must leave the window alone.
		wait_idle();
		write_reg(REG_UNUSED_2, $urandom);
		write_reg(REG_UNUSED_3, $urandom);
		run_random_phase(32'h0000_0000, 32'h0000_0000, 90);
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_window();
		test_directed_records();
		test_long_line();
		test_random_records();
		wait_idle();
		if (err_count == 0 && pending_events.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
